### hdl/three_channel_ring_fir_lowpass_core_macros.svh
// Assertion macros shared by the ring FIR low-pass core.
`ifndef THREE_CHANNEL_RING_FIR_LOWPASS_CORE_MACROS_SVH
`define THREE_CHANNEL_RING_FIR_LOWPASS_CORE_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define TCRF_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define TCRF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/tcrf_pkg.sv
// Shared constants, types and helpers of the ring FIR low-pass core.
package tcrf_pkg;

    localparam int MAX_TAPS  = 8;
    localparam int COEF_BITS = 16;
    localparam int SLOT_W    = 16;
    localparam int SAMPLE_W  = 8;
    localparam int WIN_W     = 4;
    localparam int CHANNELS  = 3;
    localparam int TAP_IDX_W = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
    localparam int PROD_W    = SAMPLE_W + COEF_BITS;
    localparam int ACC_W     = PROD_W + TAP_IDX_W;
    localparam int INT_W     = ACC_W - COEF_BITS;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 64;

    localparam logic [SAMPLE_W-1:0]   SAMPLE_MAX      = 8'hFF;
    localparam logic                  RST_ENABLE      = 1'b0;
    localparam logic [WIN_W-1:0]      RST_WINDOW      = 4'd5;
    localparam logic [CFG_DATA_W-1:0] RST_COEF_LOW    = 64'h3333_3333_3333_3333;
    localparam logic [CFG_DATA_W-1:0] RST_COEF_HIGH   = 64'h0000_0000_0000_3333;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FILTER_ENABLE = 3'd0,
        CFG_WINDOW_SIZE   = 3'd1,
        CFG_COEF_LOW      = 3'd2,
        CFG_COEF_HIGH     = 3'd3
    } cfg_index_t;

    typedef logic [SAMPLE_W-1:0] sample_t;

    typedef struct packed {
        logic                                enable;
        logic [WIN_W-1:0]                    win;
        logic [MAX_TAPS-1:0][COEF_BITS-1:0]  taps;
    } cfg_t;

    typedef struct packed {
        logic                 load;
        logic                 filt;
        logic                 step;
        logic                 finish;
        logic [TAP_IDX_W-1:0] tap_idx;
    } cmd_t;

    // Clamp a raw window setting into 1..MAX_TAPS.
    function automatic logic [WIN_W-1:0] eff_window(input logic [WIN_W-1:0] w);
        logic [WIN_W-1:0] r;
        if (w == '0)
        begin
            r = WIN_W'(1);
        end
        else if (w > WIN_W'(MAX_TAPS))
        begin
            r = WIN_W'(MAX_TAPS);
        end
        else
        begin
            r = w;
        end
        return r;
    endfunction

endpackage

### hdl/tcrf_cfg_regs.sv
// Configuration registers and tap unpacking of the ring FIR low-pass core.
module tcrf_cfg_regs (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [tcrf_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [tcrf_pkg::CFG_DATA_W-1:0]    cfg_data,
    output tcrf_pkg::cfg_t                     cfg,
    output logic                               primed_clear
);

    logic                              enable_reg;
    logic [tcrf_pkg::WIN_W-1:0]        window_reg;
    logic [tcrf_pkg::CFG_DATA_W-1:0]   coef_low_reg;
    logic [tcrf_pkg::CFG_DATA_W-1:0]   coef_high_reg;
    logic [tcrf_pkg::WIN_W-1:0]        new_window;

    assign cfg_ready  = 1'b1;
    assign new_window = cfg_data[tcrf_pkg::WIN_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg    <= tcrf_pkg::RST_ENABLE;
            window_reg    <= tcrf_pkg::RST_WINDOW;
            coef_low_reg  <= tcrf_pkg::RST_COEF_LOW;
            coef_high_reg <= tcrf_pkg::RST_COEF_HIGH;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                tcrf_pkg::CFG_FILTER_ENABLE: enable_reg    <= cfg_data[0];
                tcrf_pkg::CFG_WINDOW_SIZE:   window_reg    <= new_window;
                tcrf_pkg::CFG_COEF_LOW:      coef_low_reg  <= cfg_data;
                tcrf_pkg::CFG_COEF_HIGH:     coef_high_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Drop the primed state only when the effective window really changes.
    always_comb
    begin
        primed_clear = cfg_valid
                    && (cfg_index == tcrf_pkg::CFG_WINDOW_SIZE)
                    && (tcrf_pkg::eff_window(new_window) != tcrf_pkg::eff_window(window_reg));
    end

    always_comb
    begin
        cfg.enable = enable_reg;
        cfg.win    = tcrf_pkg::eff_window(window_reg);
        for (int i = 0; i < tcrf_pkg::MAX_TAPS; i++)
        begin
            if (i < 4)
            begin
                cfg.taps[i] = coef_low_reg[(i % 4) * tcrf_pkg::SLOT_W +: tcrf_pkg::COEF_BITS];
            end
            else
            begin
                cfg.taps[i] = coef_high_reg[(i % 4) * tcrf_pkg::SLOT_W +: tcrf_pkg::COEF_BITS];
            end
        end
    end

endmodule

### hdl/tcrf_datapath.sv
// Sample rings, multiply-accumulate lanes and output registers.
module tcrf_datapath (
    input  logic                 clk,
    input  logic                 rst_n,
    input  tcrf_pkg::cfg_t       cfg,
    input  logic                 primed_clear,
    input  tcrf_pkg::cmd_t       cmd,
    input  tcrf_pkg::sample_t    rudder_sample,
    input  tcrf_pkg::sample_t    main_engine_sample,
    input  tcrf_pkg::sample_t    sub_engine_sample,
    output tcrf_pkg::sample_t    rudder_filtered,
    output tcrf_pkg::sample_t    main_engine_filtered,
    output tcrf_pkg::sample_t    sub_engine_filtered
);

    tcrf_pkg::sample_t                  ring_reg [tcrf_pkg::CHANNELS][tcrf_pkg::MAX_TAPS];
    tcrf_pkg::sample_t                  samp_reg [tcrf_pkg::CHANNELS];
    tcrf_pkg::sample_t                  out_reg  [tcrf_pkg::CHANNELS];
    logic [tcrf_pkg::ACC_W-1:0]         acc_reg  [tcrf_pkg::CHANNELS];
    logic [tcrf_pkg::ACC_W-1:0]         acc_next [tcrf_pkg::CHANNELS];
    tcrf_pkg::sample_t                  sat_val  [tcrf_pkg::CHANNELS];
    tcrf_pkg::sample_t                  in_samp  [tcrf_pkg::CHANNELS];
    logic [tcrf_pkg::TAP_IDX_W-1:0]     wp_reg;
    logic [tcrf_pkg::TAP_IDX_W-1:0]     pos_reg;
    logic                               primed_reg;
    logic                               filt_reg;
    logic [tcrf_pkg::WIN_W:0]           j_sum;
    logic [tcrf_pkg::TAP_IDX_W-1:0]     j_idx;
    logic [tcrf_pkg::WIN_W-1:0]         win_last;
    logic [tcrf_pkg::PROD_W-1:0]        prod;
    logic [tcrf_pkg::INT_W-1:0]         int_part;

    assign in_samp[0] = rudder_sample;
    assign in_samp[1] = main_engine_sample;
    assign in_samp[2] = sub_engine_sample;

    assign rudder_filtered      = out_reg[0];
    assign main_engine_filtered = out_reg[1];
    assign sub_engine_filtered  = out_reg[2];

    assign win_last = cfg.win - tcrf_pkg::WIN_W'(1);

    // Ring slot for this tap: pos + idx, wrapped once into the window.
    always_comb
    begin
        j_sum = (tcrf_pkg::WIN_W+1)'(pos_reg) + (tcrf_pkg::WIN_W+1)'(cmd.tap_idx);
        if (j_sum >= {1'b0, cfg.win})
        begin
            j_sum = j_sum - {1'b0, cfg.win};
        end
        j_idx = j_sum[tcrf_pkg::TAP_IDX_W-1:0];
    end

    always_comb
    begin
        prod     = '0;
        int_part = '0;
        for (int c = 0; c < tcrf_pkg::CHANNELS; c++)
        begin
            prod = tcrf_pkg::PROD_W'(ring_reg[c][j_idx])
                 * tcrf_pkg::PROD_W'(cfg.taps[cmd.tap_idx]);
            acc_next[c] = acc_reg[c] + tcrf_pkg::ACC_W'(prod);
            int_part = acc_reg[c][tcrf_pkg::ACC_W-1:tcrf_pkg::COEF_BITS];
            if (int_part > tcrf_pkg::INT_W'(tcrf_pkg::SAMPLE_MAX))
            begin
                sat_val[c] = tcrf_pkg::SAMPLE_MAX;
            end
            else
            begin
                sat_val[c] = int_part[tcrf_pkg::SAMPLE_W-1:0];
            end
        end
    end

    // Control state of the rings.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            primed_reg <= 1'b0;
            wp_reg     <= '0;
        end
        else if (primed_clear)
        begin
            primed_reg <= 1'b0;
        end
        else if (cmd.load && cmd.filt)
        begin
            primed_reg <= 1'b1;
        end
        else if (cmd.finish && filt_reg)
        begin
            if (pos_reg != '0)
            begin
                wp_reg <= pos_reg - tcrf_pkg::TAP_IDX_W'(1);
            end
            else
            begin
                wp_reg <= win_last[tcrf_pkg::TAP_IDX_W-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            filt_reg <= cmd.filt;
            for (int c = 0; c < tcrf_pkg::CHANNELS; c++)
            begin
                samp_reg[c] <= in_samp[c];
                acc_reg[c]  <= '0;
            end
            if (cmd.filt)
            begin
                if (!primed_reg)
                begin
                    // First beat after reset or a window change: fill every slot.
                    pos_reg <= '0;
                    for (int c = 0; c < tcrf_pkg::CHANNELS; c++)
                    begin
                        for (int k = 0; k < tcrf_pkg::MAX_TAPS; k++)
                        begin
                            ring_reg[c][k] <= in_samp[c];
                        end
                    end
                end
                else
                begin
                    pos_reg <= wp_reg;
                    for (int c = 0; c < tcrf_pkg::CHANNELS; c++)
                    begin
                        ring_reg[c][wp_reg] <= in_samp[c];
                    end
                end
            end
        end
        if (cmd.step)
        begin
            for (int c = 0; c < tcrf_pkg::CHANNELS; c++)
            begin
                acc_reg[c] <= acc_next[c];
            end
        end
        if (cmd.finish)
        begin
            for (int c = 0; c < tcrf_pkg::CHANNELS; c++)
            begin
                out_reg[c] <= filt_reg ? sat_val[c] : samp_reg[c];
            end
        end
    end

endmodule

### hdl/tcrf_ctrl.sv
// Sequencer of the ring FIR low-pass core: accept, tap loop, result hand-off.
`include "three_channel_ring_fir_lowpass_core_macros.svh"

module tcrf_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  tcrf_pkg::cfg_t   cfg,
    input  logic             in_valid,
    output logic             in_stall,
    output logic             out_valid,
    input  logic             out_stall,
    output tcrf_pkg::cmd_t   cmd
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_MAC  = 3'b010,
        S_DONE = 3'b100
    } ctrl_state_t;

    ctrl_state_t                      state_reg, state_next;
    logic [tcrf_pkg::TAP_IDX_W-1:0]   tap_reg, tap_next;
    logic                             out_valid_reg, out_valid_next;
    logic [tcrf_pkg::WIN_W-1:0]       win_last;

    assign win_last  = cfg.win - tcrf_pkg::WIN_W'(1);
    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        tap_next       = tap_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    cmd.filt   = cfg.enable;
                    tap_next   = '0;
                    state_next = cfg.enable ? S_MAC : S_DONE;
                end
            end
            S_MAC:
            begin
                cmd.step    = 1'b1;
                cmd.tap_idx = tap_reg;
                if (tcrf_pkg::WIN_W'(tap_reg) == win_last)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    tap_next = tap_reg + tcrf_pkg::TAP_IDX_W'(1);
                end
            end
            S_DONE:
            begin
                // Hold until the output register is free or being emptied.
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.finish     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            tap_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            tap_reg       <= tap_next;
            out_valid_reg <= out_valid_next;
        end
    end

    `TCRF_ASSERT_IMP(a_tap_in_window, state_reg == S_MAC, tcrf_pkg::WIN_W'(tap_reg) < cfg.win, "tap index outside window")
    `TCRF_ASSERT_NEXT(a_bypass_to_done, (state_reg == S_IDLE) && in_valid && !cfg.enable, state_reg == S_DONE, "bypass beat skipped done")
    `TCRF_ASSERT_NEXT(a_filter_to_mac, (state_reg == S_IDLE) && in_valid && cfg.enable, (state_reg == S_MAC) && (tap_reg == '0), "filter beat did not start tap loop")
    `TCRF_ASSERT_IMP(a_finish_safe, cmd.finish, !out_valid_reg || !out_stall, "result overwrote a pending beat")

endmodule

### hdl/three_channel_ring_fir_lowpass_core.sv
// Flow: a filtered beat runs the tap loop in S_MAC and then S_DONE; a bypass beat goes
//   straight to S_DONE. in_stall stays high until S_DONE writes the output register.
//   The three multiply-accumulate lanes share a single tap loop.
// A new beat is taken while the previous result still waits in the output register.
// Reset: configuration to defaults, output empty, rings unprimed; the first filtered
//   beat after reset or a window change fills every ring slot.
module three_channel_ring_fir_lowpass_core (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  tcrf_pkg::sample_t                 rudder_sample,
    input  tcrf_pkg::sample_t                 main_engine_sample,
    input  tcrf_pkg::sample_t                 sub_engine_sample,
    output logic                              out_valid,
    input  logic                              out_stall,
    output tcrf_pkg::sample_t                 rudder_filtered,
    output tcrf_pkg::sample_t                 main_engine_filtered,
    output tcrf_pkg::sample_t                 sub_engine_filtered,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [tcrf_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [tcrf_pkg::CFG_DATA_W-1:0]   cfg_data
);

    tcrf_pkg::cfg_t  cfg;
    tcrf_pkg::cmd_t  cmd;
    logic            primed_clear;

    tcrf_cfg_regs u_cfg (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .cfg          (cfg),
        .primed_clear (primed_clear)
    );

    tcrf_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd)
    );

    tcrf_datapath u_dp (
        .clk                  (clk),
        .rst_n                (rst_n),
        .cfg                  (cfg),
        .primed_clear         (primed_clear),
        .cmd                  (cmd),
        .rudder_sample        (rudder_sample),
        .main_engine_sample   (main_engine_sample),
        .sub_engine_sample    (sub_engine_sample),
        .rudder_filtered      (rudder_filtered),
        .main_engine_filtered (main_engine_filtered),
        .sub_engine_filtered  (sub_engine_filtered)
    );

endmodule
